// ----- rtl/core/dctr_pkg.sv -----
// Package: DES tables, nonce words and shared types for the CTR keystream block.
package dctr_pkg;

    typedef logic [7:0] u8_t;

    localparam logic [63:0] KEY_RESET = 64'h5bd86c166d7ea8c3;
    localparam int ROUNDS = 16;

    typedef logic [63:0] nonce_arr_t [8];
    localparam nonce_arr_t NONCE = '{
        64'h92f4358a2ec66502, 64'h1997a4a44d0de805,
        64'h860ffa6d8628ba6d, 64'h5622c0666a4a0091,
        64'he68313f0731f13aa, 64'h8c9ae8f4227d26fe,
        64'h87ba65fd1a797c78, 64'h21a8e54e023f1119
    };

    typedef u8_t t64_t [64];
    typedef u8_t t56_t [56];
    typedef u8_t t48_t [48];
    typedef u8_t t32_t [32];

    localparam t64_t TAB_IP = '{
        58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
    localparam t64_t TAB_FP = '{
        40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
    localparam t48_t TAB_E = '{
        32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
        16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};
    localparam t32_t TAB_P = '{
        16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25};
    localparam t56_t TAB_PC1 = '{
        57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
        10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
        63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
        14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
    localparam t48_t TAB_PC2 = '{
        14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
        41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};

    typedef logic [3:0] sbox_t [8][64];
    localparam sbox_t TAB_S = '{
        '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
          4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
        '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
          0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
        '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
          13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
        '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
          10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
        '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
          4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
        '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
          9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
        '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
          1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
        '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
          7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

    localparam logic [15:0] ROT_TWO = 16'b0111_1110_1111_1100; // bit r: round r shifts by 2

    // Item passed from front to back through the queue.
    typedef struct packed {
        logic [63:0] block;
        logic [63:0] data;
        logic [7:0]  byte_enable;
    } item_t;

    function automatic logic [63:0] bswap64(input logic [63:0] x);
        logic [63:0] r;
        for (int i = 0; i < 8; i++) r[8*i +: 8] = x[8*(7-i) +: 8];
        return r;
    endfunction

    function automatic logic [63:0] perm_ip(input logic [63:0] x);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = x[64-TAB_IP[i]];
        return r;
    endfunction

    function automatic logic [63:0] perm_fp(input logic [63:0] x);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = x[64-TAB_FP[i]];
        return r;
    endfunction

    function automatic logic [55:0] perm_pc1(input logic [63:0] x);
        logic [55:0] r;
        for (int i = 0; i < 56; i++) r[55-i] = x[64-TAB_PC1[i]];
        return r;
    endfunction

    function automatic logic [47:0] perm_pc2(input logic [55:0] x);
        logic [47:0] r;
        for (int i = 0; i < 48; i++) r[47-i] = x[56-TAB_PC2[i]];
        return r;
    endfunction

    function automatic logic [27:0] rot28(input logic [27:0] x, input logic two);
        return two ? {x[25:0], x[27:26]} : {x[26:0], x[27]};
    endfunction

    function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
        logic [47:0] e;
        logic [31:0] o;
        logic [5:0]  six;
        logic [31:0] p;
        for (int i = 0; i < 48; i++) e[47-i] = r[32-TAB_E[i]];
        e = e ^ k;
        for (int s = 0; s < 8; s++)
        begin
            six = e[42-6*s +: 6];
            o[28-4*s +: 4] = TAB_S[s][{six[5], six[0], six[4:1]}];
        end
        for (int i = 0; i < 32; i++) p[31-i] = o[32-TAB_P[i]];
        return p;
    endfunction

endpackage

// ----- rtl/core/dctr_front.sv -----
// Front end: accepts items and forms the counter block for each.
module dctr_front
    import dctr_pkg::*;
#(
    parameter int BLOCK_LOG2 = 6
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [60:0] word_index,
    input  logic [63:0] data_in,
    input  logic [7:0]  byte_enable,
    output logic        q_valid,
    input  logic        q_ready,
    output item_t       q_item
);
    localparam int WLOG = BLOCK_LOG2 - 3;

    logic        valid_reg;
    item_t       item_reg;
    logic [60:0] count;
    logic [2:0]  sel;

    assign count = word_index >> WLOG;
    assign sel   = 3'(word_index & ((61'd1 << WLOG) - 61'd1));

    assign in_ready = !valid_reg || q_ready;
    assign q_valid  = valid_reg;
    assign q_item   = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.block       <= bswap64(NONCE[sel] ^ {3'b000, count});
            item_reg.data        <= data_in;
            item_reg.byte_enable <= byte_enable;
        end
    end
endmodule

// ----- rtl/core/dctr_queue.sv -----
// Two-entry queue between front and back ends.
module dctr_queue
    import dctr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_valid,
    output logic  wr_ready,
    input  item_t wr_item,
    output logic  rd_valid,
    input  logic  rd_ready,
    output item_t rd_item
);
    item_t      mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_item  = mem_reg[rp_reg];
    assign push = wr_valid && wr_ready;
    assign pop  = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= !wp_reg;
            if (pop)  rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wp_reg] <= wr_item;
    end
endmodule

// ----- rtl/core/dctr_back.sv -----
// Back end: DES pipeline of an entry stage and 16 round stages, then keystream XOR with output register.
module dctr_back
    import dctr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [63:0] des_key,
    input  logic        q_valid,
    output logic        q_ready,
    input  item_t       q_item,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] data_out
);
    localparam int NS = ROUNDS + 1; // entry stage, 16 rounds

    logic        vld_reg [NS];
    logic [31:0] l_reg   [NS];
    logic [31:0] r_reg   [NS];
    logic [27:0] c_reg   [NS];
    logic [27:0] d_reg   [NS];
    logic [63:0] dat_reg [NS];
    logic [7:0]  be_reg  [NS];
    logic        adv;
    logic [63:0] ip;
    logic [55:0] cd;
    logic [63:0] ks, mask;

    // Whole pipe advances together; a bubble-free stall keeps it simple.
    assign adv     = !out_valid || out_ready;
    assign q_ready = adv;

    assign ip = perm_ip(q_item.block);
    assign cd = perm_pc1(bswap64(des_key));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++) vld_reg[i] <= 1'b0;
            out_valid <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= q_valid;
            for (int i = 1; i < NS; i++) vld_reg[i] <= vld_reg[i-1];
            out_valid <= vld_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l_reg[0]   <= ip[63:32];
            r_reg[0]   <= ip[31:0];
            c_reg[0]   <= cd[55:28];
            d_reg[0]   <= cd[27:0];
            dat_reg[0] <= q_item.data;
            be_reg[0]  <= q_item.byte_enable;
            data_out   <= dat_reg[NS-1] ^ (ks & mask);
        end
    end

    for (genvar g = 1; g < NS; g++)
    begin : g_round
        logic [27:0] cn, dn;
        assign cn = rot28(c_reg[g-1], ROT_TWO[g-1]);
        assign dn = rot28(d_reg[g-1], ROT_TWO[g-1]);
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                c_reg[g]   <= cn;
                d_reg[g]   <= dn;
                l_reg[g]   <= r_reg[g-1];
                r_reg[g]   <= l_reg[g-1] ^ feistel(r_reg[g-1], perm_pc2({cn, dn}));
                dat_reg[g] <= dat_reg[g-1];
                be_reg[g]  <= be_reg[g-1];
            end
        end
    end

    assign ks = bswap64(perm_fp({r_reg[NS-1], l_reg[NS-1]}));
    always_comb
    begin
        for (int i = 0; i < 8; i++) mask[8*i +: 8] = {8{be_reg[NS-1][i]}};
    end
endmodule

// ----- rtl/core/des_ctr_keystream_xor.sv -----
// Top level: DES counter-mode keystream XOR over 64-bit file words.
//
// Usage:
//  - Input channel (in_valid/in_ready) carries one file word per transaction:
//    word_index, data_in, byte_enable. Output channel (out_valid/out_ready)
//    returns data_out, one transaction per input, in order.
//  - Config channel (cfg_valid/cfg_ready, cfg_data) writes the DES key; it is
//    always ready and must be written only while the block is idle.
//  - Throughput: one word per cycle sustained while out_ready stays high; the
//    16 DES rounds are one pipeline stage each.
//  - Path: an accepted item passes 20 registers in order (front register,
//    queue, key/IP entry stage, 16 round stages, output register) before
//    out_valid rises; the first is loaded at the input transaction edge.
//  - When the receiver stalls, the DES pipe freezes; the two-entry queue and
//    front register absorb items until in_ready drops.
//  - Reset clears all valid state and loads the default key.
module des_ctr_keystream_xor
    import dctr_pkg::*;
#(
    parameter int BLOCK_LOG2 = 6
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [60:0] word_index,
    input  logic [63:0] data_in,
    input  logic [7:0]  byte_enable,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] data_out,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] cfg_data
);
    logic [63:0] key_reg;
    logic        f_valid, f_ready, b_valid, b_ready;
    item_t       f_item, b_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            key_reg <= KEY_RESET;
        else if (cfg_valid)
            key_reg <= cfg_data;
    end

    // Front: counter block formation.
    dctr_front #(.BLOCK_LOG2(BLOCK_LOG2)) u_front (
        .clk, .rst_n, .in_valid, .in_ready, .word_index, .data_in, .byte_enable,
        .q_valid(f_valid), .q_ready(f_ready), .q_item(f_item));

    // Decoupling queue.
    dctr_queue u_queue (
        .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
        .rd_valid(b_valid), .rd_ready(b_ready), .rd_item(b_item));

    // Back: DES rounds and XOR.
    dctr_back u_back (
        .clk, .rst_n, .des_key(key_reg), .q_valid(b_valid), .q_ready(b_ready),
        .q_item(b_item), .out_valid, .out_ready, .data_out);

    // A stalled output must hold its data.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data_out))
        else $error("output changed under stall");

    // The back pipe only takes from the queue when it can advance.
    a_q_flow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !b_ready)
        else $error("queue popped while pipe stalled");

    // Front register never drops an item the queue refused.
    a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
        f_valid && !f_ready |=> f_valid && $stable(f_item))
        else $error("front item lost");
endmodule
